[rtl/frops_pkg.sv]
// Shared types and constants for the fragment raster operations block.
// No dependencies; all other files but frops_ram use its scoped names.

package frops_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_FLAGS  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_COMPARE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCISSOR_X_MIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCISSOR_Y_MIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCISSOR_X_MAX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCISSOR_Y_MAX = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 3'd6;

    // enable_flags bit positions
    localparam int EN_SCISSOR = 0;
    localparam int EN_DEPTH   = 1;
    localparam int EN_BLEND   = 2;

    // depth compare modes; other codes always fail
    localparam logic [1:0] CMP_LESS    = 2'd0;
    localparam logic [1:0] CMP_GREATER = 2'd1;

    typedef logic [1:0] fate_t;

    localparam fate_t FATE_WRITTEN    = 2'd0;
    localparam fate_t FATE_SCISSORED  = 2'd1;
    localparam fate_t FATE_DEPTH_FAIL = 2'd2;
    localparam fate_t FATE_RANGE      = 2'd3;

    // y*width+x with 8-bit y, 9-bit width and 8-bit x fits in 17 bits
    localparam int IDX_W   = 17;
    localparam int FDEPTH_W = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [2:0] enable_flags;
        logic [1:0] depth_compare_mode;
        logic [8:0] scissor_x_min;
        logic [8:0] scissor_y_min;
        logic [8:0] scissor_x_max;
        logic [8:0] scissor_y_max;
        logic [8:0] frame_width;
    } cfg_t;

    typedef struct packed {
        logic [7:0]          frag_x;
        logic [7:0]          frag_y;
        logic [FDEPTH_W-1:0] frag_depth;
        logic [7:0]          src_red;
        logic [7:0]          src_green;
        logic [7:0]          src_blue;
        logic [7:0]          src_alpha;
    } frag_t;

    typedef struct packed {
        fate_t       fate;
        logic [15:0] pixel_index;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
    } result_t;

    // Classified fragment handed from front to back.
    // fate is FATE_WRITTEN for fragments that still need the stores.
    typedef struct packed {
        fate_t               fate;
        logic [IDX_W-1:0]    idx;
        logic [FDEPTH_W-1:0] depth;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          alpha;
    } entry_t;

endpackage

[rtl/fragment_raster_ops.sv]
// Top level of the fragment raster operations block: configuration registers,
// front end, request queue and back end. Depends on frops_pkg and submodules.

// Takes one fragment per cycle and returns one result per cycle while the
// output side is not stalled; a request passes through the queue and store
// read, then depth test and blend products, then divide and store write. Both
// stores are read and written once per cycle on their own ports, with
// back-to-back requests to the same pixel served by forwarding.
// After reset the block sweeps both stores, one entry per cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries (65536 with the defaults); in_stall stays high
// during the sweep, while configuration writes are taken as usual.
// Configuration must only be written while no request is in flight.

module fragment_raster_ops #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  frops_pkg::frag_t                      in_frag,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output frops_pkg::result_t                    out_result,
    input  logic                                  cfg_write,
    input  logic [frops_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [frops_pkg::CFG_DATA_W-1:0]      cfg_data
);

    frops_pkg::cfg_t   cfg_reg;
    frops_pkg::cfg_t   cfg_next;
    logic              queue_full;
    logic              clearing;
    logic              push;
    frops_pkg::entry_t push_entry;
    logic              pop;
    logic              head_valid;
    frops_pkg::entry_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                frops_pkg::CFG_ENABLE_FLAGS:  cfg_next.enable_flags       = cfg_data[2:0];
                frops_pkg::CFG_DEPTH_COMPARE: cfg_next.depth_compare_mode = cfg_data[1:0];
                frops_pkg::CFG_SCISSOR_X_MIN: cfg_next.scissor_x_min      = cfg_data;
                frops_pkg::CFG_SCISSOR_Y_MIN: cfg_next.scissor_y_min      = cfg_data;
                frops_pkg::CFG_SCISSOR_X_MAX: cfg_next.scissor_x_max      = cfg_data;
                frops_pkg::CFG_SCISSOR_Y_MAX: cfg_next.scissor_y_max      = cfg_data;
                frops_pkg::CFG_FRAME_WIDTH:   cfg_next.frame_width        = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_flags       <= '0;
            cfg_reg.depth_compare_mode <= '0;
            cfg_reg.scissor_x_min      <= 9'd0;
            cfg_reg.scissor_y_min      <= 9'd0;
            cfg_reg.scissor_x_max      <= 9'd256;
            cfg_reg.scissor_y_max      <= 9'd256;
            cfg_reg.frame_width        <= 9'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    frops_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frag       (in_frag),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .entry      (push_entry)
    );

    frops_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    frops_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (head_valid),
        .q_head     (head),
        .q_pop      (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

endmodule

[rtl/frops_ram.sv]
// Generic single write port / single read port RAM with registered read.
// Read-first: a read and a write at the same address return the old word.

module frops_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/frops_front.sv]
// Front end: accepts fragments, applies the scissor test, forms the pixel
// index and flags out-of-range indexes. Depends on frops_pkg.

module frops_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic              in_valid,
    output logic              in_stall,
    input  frops_pkg::frag_t  frag,
    input  frops_pkg::cfg_t   cfg,
    input  logic              queue_full,
    input  logic              clearing,
    output logic              push,
    output frops_pkg::entry_t entry
);

    localparam logic [31:0] STORE_LIMIT = 32'(MAX_WIDTH * MAX_HEIGHT);

    logic                          in_rect;
    logic                          scissored;
    logic [frops_pkg::IDX_W-1:0]   idx;
    logic                          out_of_range;

    always_comb
    begin
        in_rect = ({1'b0, frag.frag_x} >= cfg.scissor_x_min) &&
                  ({1'b0, frag.frag_x} <  cfg.scissor_x_max) &&
                  ({1'b0, frag.frag_y} >= cfg.scissor_y_min) &&
                  ({1'b0, frag.frag_y} <  cfg.scissor_y_max);
        scissored = cfg.enable_flags[frops_pkg::EN_SCISSOR] && !in_rect;

        idx = frops_pkg::IDX_W'(frag.frag_y) * frops_pkg::IDX_W'(cfg.frame_width) +
              frops_pkg::IDX_W'(frag.frag_x);
        out_of_range = 32'(idx) >= STORE_LIMIT;

        entry.depth = frag.frag_depth;
        entry.red   = frag.src_red;
        entry.green = frag.src_green;
        entry.blue  = frag.src_blue;
        entry.alpha = frag.src_alpha;
        if (scissored)
        begin
            entry.fate = frops_pkg::FATE_SCISSORED;
            entry.idx  = '0;
        end
        else if (out_of_range)
        begin
            entry.fate = frops_pkg::FATE_RANGE;
            entry.idx  = idx;
        end
        else
        begin
            entry.fate = frops_pkg::FATE_WRITTEN;
            entry.idx  = idx;
        end
    end

    assign in_stall = queue_full || clearing;
    assign push     = in_valid && !in_stall;

endmodule

[rtl/frops_queue.sv]
// Short FIFO of classified fragments between front and back end.
// Depends on frops_pkg for the entry type and depth.

module frops_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  frops_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output frops_pkg::entry_t head
);

    frops_pkg::entry_t                mem_reg [frops_pkg::QUEUE_DEPTH];
    logic [frops_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [frops_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [frops_pkg::QCNT_W-1:0]     count_reg;
    logic [frops_pkg::QCNT_W-1:0]     count_next;

    assign full       = count_reg == frops_pkg::QCNT_W'(frops_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // front must hold off while full; back must not pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue underflow");

endmodule

[rtl/frops_back.sv]
// Back end: depth test, alpha blend and store update with forwarding,
// plus the post-reset clearing sweep. Depends on frops_pkg and frops_ram.

module frops_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  frops_pkg::cfg_t    cfg,
    input  logic               q_valid,
    input  frops_pkg::entry_t  q_head,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output frops_pkg::result_t out_result
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = STORE_SIZE > 1 ? $clog2(STORE_SIZE) : 1;

    typedef struct packed {
        frops_pkg::fate_t              fate;
        logic [frops_pkg::IDX_W-1:0]   idx;
        logic                          write;
        logic                          blend;
        logic [3:0][7:0]               src;
        logic [3:0][15:0]              sums;
    } stage2_t;

    // exact v/255 for v <= 255*255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic                     clearing_reg;
    logic [ADDR_W-1:0]        clear_addr_reg;

    logic                     adv;
    logic                     s1_valid_reg;
    frops_pkg::entry_t        s1_entry_reg;
    logic                     s2_valid_reg;
    stage2_t                  s2_reg;
    stage2_t                  s2_next;
    logic                     out_valid_reg;
    frops_pkg::result_t       out_result_reg;
    frops_pkg::result_t       out_result_next;

    logic                     dfwd_valid_reg;
    logic [ADDR_W-1:0]        dfwd_addr_reg;
    logic [DEPTH_BITS-1:0]    dfwd_data_reg;
    logic                     cfwd_valid_reg;
    logic [ADDR_W-1:0]        cfwd_addr_reg;
    logic [31:0]              cfwd_data_reg;

    logic [DEPTH_BITS-1:0]    depth_rdata;
    logic [31:0]              color_rdata;
    logic                     depth_we;
    logic [ADDR_W-1:0]        depth_waddr;
    logic [DEPTH_BITS-1:0]    depth_wdata;
    logic                     color_we;
    logic [ADDR_W-1:0]        color_waddr;
    logic [31:0]              color_wdata;
    logic [ADDR_W-1:0]        rd_addr;

    logic                     live;
    logic [ADDR_W-1:0]        s1_addr;
    logic [ADDR_W-1:0]        s2_addr;
    logic [DEPTH_BITS-1:0]    z;
    logic [DEPTH_BITS-1:0]    stored_depth;
    logic                     pass;
    logic                     depth_on;
    logic                     depth_fail;
    logic                     s1_write;
    logic                     depth_pipe_we;
    logic                     color_pipe_we;
    logic [3:0][7:0]          s2_color;
    logic [3:0][7:0]          dst;
    logic [3:0][7:0]          src;

    assign adv      = !out_valid_reg || !out_stall;
    assign q_pop    = adv && q_valid && !clearing_reg;
    assign clearing = clearing_reg;
    assign rd_addr  = ADDR_W'(q_head.idx);

    // stage 1: depth test and blend products
    always_comb
    begin
        live     = s1_valid_reg && (s1_entry_reg.fate == frops_pkg::FATE_WRITTEN);
        s1_addr  = ADDR_W'(s1_entry_reg.idx);
        s2_addr  = ADDR_W'(s2_reg.idx);
        z        = DEPTH_BITS'(s1_entry_reg.depth);
        depth_on = cfg.enable_flags[frops_pkg::EN_DEPTH];

        // forward the last depth write; it may have landed in the same edge as this read
        if (dfwd_valid_reg && dfwd_addr_reg == s1_addr)
        begin
            stored_depth = dfwd_data_reg;
        end
        else
        begin
            stored_depth = depth_rdata;
        end

        unique case (cfg.depth_compare_mode)
            frops_pkg::CMP_LESS:    pass = z < stored_depth;
            frops_pkg::CMP_GREATER: pass = z > stored_depth;
            default:                pass = 1'b0;
        endcase

        depth_fail    = live && depth_on && !pass;
        s1_write      = live && !depth_fail;
        depth_pipe_we = adv && s1_write && depth_on;

        for (int c = 0; c < 4; c++)
        begin
            if (s2_reg.blend)
            begin
                s2_color[c] = div255(s2_reg.sums[c]);
            end
            else
            begin
                s2_color[c] = s2_reg.src[c];
            end
        end

        // newest color first: item in stage 2, then the last write, then RAM
        if (s2_valid_reg && s2_reg.write && s2_addr == s1_addr)
        begin
            dst = s2_color;
        end
        else if (cfwd_valid_reg && cfwd_addr_reg == s1_addr)
        begin
            dst = cfwd_data_reg;
        end
        else
        begin
            dst = color_rdata;
        end

        src = {s1_entry_reg.alpha, s1_entry_reg.blue, s1_entry_reg.green, s1_entry_reg.red};

        s2_next.fate  = depth_fail ? frops_pkg::FATE_DEPTH_FAIL : s1_entry_reg.fate;
        s2_next.idx   = s1_entry_reg.idx;
        s2_next.write = s1_write;
        s2_next.blend = cfg.enable_flags[frops_pkg::EN_BLEND];
        s2_next.src   = src;
        for (int c = 0; c < 4; c++)
        begin
            s2_next.sums[c] = 16'(src[c]) * 16'(s1_entry_reg.alpha) +
                              16'(dst[c]) * 16'(8'd255 - s1_entry_reg.alpha);
        end
    end

    // stage 2: divide, color write, result
    always_comb
    begin
        color_pipe_we = adv && s2_valid_reg && s2_reg.write;

        out_result_next.fate        = s2_reg.fate;
        out_result_next.pixel_index = s2_reg.idx[15:0];
        if (s2_reg.write)
        begin
            out_result_next.out_red   = s2_color[0];
            out_result_next.out_green = s2_color[1];
            out_result_next.out_blue  = s2_color[2];
            out_result_next.out_alpha = s2_color[3];
        end
        else
        begin
            out_result_next.out_red   = '0;
            out_result_next.out_green = '0;
            out_result_next.out_blue  = '0;
            out_result_next.out_alpha = '0;
        end
    end

    // RAM write ports: clearing sweep or pipeline
    always_comb
    begin
        if (clearing_reg)
        begin
            depth_we    = 1'b1;
            depth_waddr = clear_addr_reg;
            depth_wdata = '1;
            color_we    = 1'b1;
            color_waddr = clear_addr_reg;
            color_wdata = '0;
        end
        else
        begin
            depth_we    = depth_pipe_we;
            depth_waddr = s1_addr;
            depth_wdata = z;
            color_we    = color_pipe_we;
            color_waddr = s2_addr;
            color_wdata = s2_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            dfwd_valid_reg <= 1'b0;
            cfwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == ADDR_W'(STORE_SIZE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                s1_valid_reg  <= q_pop;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
            if (depth_pipe_we)
            begin
                dfwd_valid_reg <= 1'b1;
            end
            if (color_pipe_we)
            begin
                cfwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_entry_reg <= q_head;
        end
        if (adv)
        begin
            s2_reg         <= s2_next;
            out_result_reg <= out_result_next;
        end
        if (depth_pipe_we)
        begin
            dfwd_addr_reg <= s1_addr;
            dfwd_data_reg <= z;
        end
        if (color_pipe_we)
        begin
            cfwd_addr_reg <= s2_addr;
            cfwd_data_reg <= s2_color;
        end
    end

    frops_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_SIZE)
    ) u_depth_ram (
        .clk   (clk),
        .we    (depth_we),
        .waddr (depth_waddr),
        .wdata (depth_wdata),
        .re    (q_pop),
        .raddr (rd_addr),
        .rdata (depth_rdata)
    );

    frops_ram #(
        .WIDTH (32),
        .DEPTH (STORE_SIZE)
    ) u_color_ram (
        .clk   (clk),
        .we    (color_we),
        .waddr (color_waddr),
        .wdata (color_wdata),
        .re    (q_pop),
        .raddr (rd_addr),
        .rdata (color_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("request in flight during clearing sweep");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.fate != frops_pkg::FATE_WRITTEN) |->
        (out_result_reg.out_red == '0 && out_result_reg.out_green == '0 &&
         out_result_reg.out_blue == '0 && out_result_reg.out_alpha == '0))
        else $error("color reported for a request that was not written");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.fate == frops_pkg::FATE_SCISSORED) |->
        out_result_reg.pixel_index == '0)
        else $error("scissored request carries a pixel index");

endmodule
